// File: rtl/chr_pkg.sv
// shared types, codes and reset values for the capture health reconnect block
package chr_pkg;

  // request types
  localparam logic [1:0] REQ_OPEN  = 2'd0;
  localparam logic [1:0] REQ_CLOSE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  // modes
  localparam logic [2:0] M_CLOSED  = 3'd0;
  localparam logic [2:0] M_OPENING = 3'd1;
  localparam logic [2:0] M_PLAYING = 3'd2;
  localparam logic [2:0] M_RECONN  = 3'd3;
  localparam logic [2:0] M_ERROR   = 3'd4;
  localparam logic [2:0] M_STOPPED = 3'd5;

  // fault codes
  localparam logic [2:0] F_NONE      = 3'd0;
  localparam logic [2:0] F_BAD_INDEX = 3'd1;
  localparam logic [2:0] F_OPEN_FAIL = 3'd2;
  localparam logic [2:0] F_RETRIES   = 3'd3;
  localparam logic [2:0] F_BLACK     = 3'd4;
  localparam logic [2:0] F_READS     = 3'd5;

  // reconnect causes
  localparam logic [1:0] C_NONE  = 2'd0;
  localparam logic [1:0] C_BLACK = 2'd1;
  localparam logic [1:0] C_READS = 2'd2;

  // configuration register indexes
  localparam logic [2:0] R_MAX_READ_FAILURES  = 3'd0;
  localparam logic [2:0] R_MAX_BLACK_FRAMES   = 3'd1;
  localparam logic [2:0] R_MAX_RETRY_ATTEMPTS = 3'd2;
  localparam logic [2:0] R_RETRY_BASE_DELAY   = 3'd3;
  localparam logic [2:0] R_BLACK_LEVEL        = 3'd4;

  // configuration reset values
  localparam logic [7:0]  RST_MAX_READ_FAILURES  = 8'd15;
  localparam logic [7:0]  RST_MAX_BLACK_FRAMES   = 8'd25;
  localparam logic [3:0]  RST_MAX_RETRY_ATTEMPTS = 4'd3;
  localparam logic [15:0] RST_RETRY_BASE_DELAY   = 16'd2000;
  localparam logic [15:0] RST_BLACK_LEVEL        = 16'd256;

  // largest camera index that may be opened
  localparam logic [7:0] MAX_INDEX = 8'd15;
  // saturation point of the failure and black counters
  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic [7:0]  max_read_failures;
    logic [7:0]  max_black_frames;
    logic [3:0]  max_retry_attempts;
    logic [15:0] retry_base_delay;
    logic [15:0] black_level;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  camera_index;
    logic        open_ok;
    logic        frame_ok;
    logic [15:0] mean_ch0;
    logic [15:0] mean_ch1;
    logic [15:0] mean_ch2;
  } req_t;

  typedef struct packed {
    logic        frame_accepted;
    logic [2:0]  mode;
    logic [2:0]  fault_code;
    logic [3:0]  attempts_used;
    logic [1:0]  retry_cause;
    logic        release_device;
  } rsp_t;

endpackage

// File: rtl/chr_cfg_regs.sv
// configuration register file for the capture health reconnect block
module chr_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output chr_pkg::cfg_t cfg
);
  import chr_pkg::*;

  // writes are taken in any cycle
  assign cfg_ready = 1'b1;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_read_failures  <= RST_MAX_READ_FAILURES;
      cfg.max_black_frames   <= RST_MAX_BLACK_FRAMES;
      cfg.max_retry_attempts <= RST_MAX_RETRY_ATTEMPTS;
      cfg.retry_base_delay   <= RST_RETRY_BASE_DELAY;
      cfg.black_level        <= RST_BLACK_LEVEL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        R_MAX_READ_FAILURES:  cfg.max_read_failures  <= cfg_data[7:0];
        R_MAX_BLACK_FRAMES:   cfg.max_black_frames   <= cfg_data[7:0];
        R_MAX_RETRY_ATTEMPTS: cfg.max_retry_attempts <= cfg_data[3:0];
        R_RETRY_BASE_DELAY:   cfg.retry_base_delay   <= cfg_data;
        R_BLACK_LEVEL:        cfg.black_level        <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/chr_core.sv
// health monitor state and per-request update logic
module chr_core (
  input  logic          clk,
  input  logic          rst,
  input  chr_pkg::cfg_t cfg,
  input  logic          step,
  input  chr_pkg::req_t item,
  output chr_pkg::rsp_t res
);
  import chr_pkg::*;

  logic [2:0]  mode_reg, mode_reg_next;
  logic [3:0]  active_index, active_index_next;
  logic        index_valid, index_valid_next;
  logic [7:0]  fail_count, fail_count_next;
  logic [7:0]  black_count, black_count_next;
  logic [3:0]  attempt_count, attempt_count_next;
  logic [19:0] wait_remaining, wait_remaining_next;
  logic [1:0]  cause_reg, cause_reg_next;
  logic [2:0]  fault_reg, fault_reg_next;
  logic        accepted, release_dev;

  // helpers for scheduling and frame checks
  logic        can_sched;
  logic [3:0]  att_inc;
  logic [19:0] sched_wait;
  logic        is_black;
  logic [7:0]  fail_inc, black_inc;

  assign can_sched  = attempt_count < cfg.max_retry_attempts;
  assign att_inc    = attempt_count + 4'd1;
  assign sched_wait = cfg.retry_base_delay * att_inc;
  assign is_black   = (item.mean_ch0 < cfg.black_level) &&
                      (item.mean_ch1 < cfg.black_level) &&
                      (item.mean_ch2 < cfg.black_level);
  assign fail_inc   = (fail_count < COUNT_MAX) ? fail_count + 8'd1 : fail_count;
  assign black_inc  = (black_count < COUNT_MAX) ? black_count + 8'd1 : black_count;

  // next state for one request
  always_comb begin
    mode_reg_next       = mode_reg;
    active_index_next   = active_index;
    index_valid_next    = index_valid;
    fail_count_next     = fail_count;
    black_count_next    = black_count;
    attempt_count_next  = attempt_count;
    wait_remaining_next = wait_remaining;
    cause_reg_next      = cause_reg;
    fault_reg_next      = fault_reg;
    accepted            = 1'b0;
    release_dev         = 1'b0;

    unique case (item.req_type)
      REQ_OPEN: begin
        release_dev         = 1'b1;
        active_index_next   = '0;
        index_valid_next    = 1'b0;
        fail_count_next     = '0;
        black_count_next    = '0;
        attempt_count_next  = '0;
        wait_remaining_next = '0;
        cause_reg_next      = C_NONE;
        if (item.camera_index > MAX_INDEX) begin
          fault_reg_next = F_BAD_INDEX;
          mode_reg_next  = M_ERROR;
        end else if (!item.open_ok) begin
          fault_reg_next = F_OPEN_FAIL;
          mode_reg_next  = M_ERROR;
        end else begin
          fault_reg_next    = F_NONE;
          active_index_next = item.camera_index[3:0];
          index_valid_next  = 1'b1;
          mode_reg_next     = M_PLAYING;
        end
      end
      REQ_CLOSE: begin
        release_dev         = 1'b1;
        active_index_next   = '0;
        index_valid_next    = 1'b0;
        fail_count_next     = '0;
        black_count_next    = '0;
        attempt_count_next  = '0;
        wait_remaining_next = '0;
        cause_reg_next      = C_NONE;
        fault_reg_next      = F_NONE;
        if (mode_reg != M_CLOSED && mode_reg != M_STOPPED) begin
          mode_reg_next = M_STOPPED;
        end
      end
      REQ_TICK: begin
        if (wait_remaining != '0) begin
          wait_remaining_next = wait_remaining - 20'd1;
        end
      end
      default: begin
        // read event
        if (mode_reg == M_RECONN) begin
          if (wait_remaining == '0) begin
            release_dev = 1'b1;
            if (item.open_ok) begin
              fail_count_next  = '0;
              black_count_next = '0;
              cause_reg_next   = C_NONE;
              fault_reg_next   = F_NONE;
              mode_reg_next    = M_PLAYING;
            end else if (can_sched) begin
              attempt_count_next  = att_inc;
              wait_remaining_next = sched_wait;
              fault_reg_next      = F_NONE;
            end else begin
              active_index_next = '0;
              index_valid_next  = 1'b0;
              fail_count_next   = '0;
              black_count_next  = '0;
              cause_reg_next    = C_NONE;
              fault_reg_next    = F_RETRIES;
              mode_reg_next     = M_ERROR;
            end
          end
        end else if (mode_reg == M_PLAYING) begin
          if (item.frame_ok) begin
            fail_count_next = '0;
            if (is_black) begin
              black_count_next = black_inc;
              if (black_inc >= cfg.max_black_frames) begin
                release_dev = 1'b1;
                if (can_sched) begin
                  attempt_count_next  = att_inc;
                  wait_remaining_next = sched_wait;
                  cause_reg_next      = C_BLACK;
                  fault_reg_next      = F_NONE;
                  mode_reg_next       = M_RECONN;
                end else begin
                  active_index_next   = '0;
                  index_valid_next    = 1'b0;
                  fail_count_next     = '0;
                  black_count_next    = '0;
                  wait_remaining_next = '0;
                  cause_reg_next      = C_NONE;
                  fault_reg_next      = F_BLACK;
                  mode_reg_next       = M_ERROR;
                end
              end
            end else begin
              black_count_next   = '0;
              attempt_count_next = '0;
              accepted           = 1'b1;
            end
          end else begin
            fail_count_next = fail_inc;
            if (fail_inc >= cfg.max_read_failures) begin
              release_dev = 1'b1;
              if (can_sched) begin
                attempt_count_next  = att_inc;
                wait_remaining_next = sched_wait;
                cause_reg_next      = C_READS;
                fault_reg_next      = F_NONE;
                mode_reg_next       = M_RECONN;
              end else begin
                active_index_next   = '0;
                index_valid_next    = 1'b0;
                fail_count_next     = '0;
                black_count_next    = '0;
                wait_remaining_next = '0;
                cause_reg_next      = C_NONE;
                fault_reg_next      = F_READS;
                mode_reg_next       = M_ERROR;
              end
            end
          end
        end
      end
    endcase
  end

  // result reflects state after the request
  always_comb begin
    res.frame_accepted = accepted;
    res.mode           = mode_reg_next;
    res.fault_code     = fault_reg_next;
    res.attempts_used  = attempt_count_next;
    res.retry_cause    = cause_reg_next;
    res.release_device = release_dev;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg       <= M_CLOSED;
      active_index   <= '0;
      index_valid    <= 1'b0;
      fail_count     <= '0;
      black_count    <= '0;
      attempt_count  <= '0;
      wait_remaining <= '0;
      cause_reg      <= C_NONE;
      fault_reg      <= F_NONE;
    end else if (step) begin
      mode_reg       <= mode_reg_next;
      active_index   <= active_index_next;
      index_valid    <= index_valid_next;
      fail_count     <= fail_count_next;
      black_count    <= black_count_next;
      attempt_count  <= attempt_count_next;
      wait_remaining <= wait_remaining_next;
      cause_reg      <= cause_reg_next;
      fault_reg      <= fault_reg_next;
    end
  end

`ifndef SYNTH
  // opening is passed through within one request
  a_no_opening: assert property (@(posedge clk) disable iff (rst)
    mode_reg != M_OPENING) else $error("opening mode held in state");

  // a pending cause or delay exists only while reconnecting
  a_cause_reconn: assert property (@(posedge clk) disable iff (rst)
    (cause_reg != C_NONE || wait_remaining != '0) |-> mode_reg == M_RECONN)
    else $error("reconnect cause or delay outside reconnecting");

  // a fault is reported only in error
  a_fault_error: assert property (@(posedge clk) disable iff (rst)
    (fault_reg != F_NONE) |-> mode_reg == M_ERROR)
    else $error("fault code outside error mode");

  // a held index implies an active device
  a_index_active: assert property (@(posedge clk) disable iff (rst)
    index_valid |-> (mode_reg == M_PLAYING || mode_reg == M_RECONN))
    else $error("index valid while device inactive");
`endif

endmodule

// File: rtl/capture_health_reconnect_fsm.sv
// top level of the capture health reconnect block: request and result registers
// Health monitor and reconnect controller for a frame source.
// Request channel (req_valid, req_stall, req_data): one request is open,
// close, read event or one elapsed tick; it is taken at a rising edge with
// req_valid high and req_stall low.
// Result channel (rsp_valid, rsp_stall, rsp_data): exactly one result per
// request, in order, taken at an edge with rsp_valid high and rsp_stall low.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): writes
// the limit, delay and black level registers; write only while idle.
// A request waits in the request register, where the whole state update is
// evaluated in one pass (one 16x4 multiply for the retry delay), and the
// result is written to the result register when the request moves on.
// Throughput is one request per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds; one more request
// may wait in the request register, after which req_stall goes high.
// Synchronous reset returns all state to closed with defaults loaded in the
// configuration registers, and empties both registers.
module capture_health_reconnect_fsm (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  chr_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output chr_pkg::rsp_t rsp_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  import chr_pkg::*;

  cfg_t cfg;
  req_t hold_req;
  logic hold_valid;
  logic advance;
  rsp_t res;

  chr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // held request moves on when the result register is free or draining
  assign advance   = hold_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = hold_valid && !advance;

  chr_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (advance),
    .item (hold_req),
    .res  (res)
  );

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!req_stall) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      hold_req <= req_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_data <= res;
    end
  end

endmodule

// File: tb/sv/tb_capture_health_reconnect_fsm.sv
// self-checking testbench for the capture health reconnect block
`timescale 1ns / 1ps

module tb_capture_health_reconnect_fsm;
  import chr_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int REQ_W = $bits(req_t);
  localparam int NUM_PHASES = 12;
  // index past the last register, a write there changes nothing
  localparam logic [2:0] R_UNUSED = 3'd7;

  typedef enum {RD_FAIL, RD_BLACK, RD_GOOD} read_kind_t;

  typedef struct {
    logic [2:0]  mode;
    logic [3:0]  act_idx;
    logic        idx_valid;
    logic [7:0]  fails;
    logic [7:0]  blacks;
    logic [3:0]  attempts;
    logic [19:0] wait_left;
    logic [1:0]  cause;
    logic [2:0]  fault;
  } health_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req_data = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // stimulus and expectation stores
  req_t          request_q[$];
  rsp_t          expected_status_q[$];
  health_state_t plan_state;
  health_state_t live_state;
  cfg_t          model_cfg;

  int n_pushed = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_frames = 0;
  int n_retries = 0;
  int n_cfg_writes = 0;
  int n_fail = 0;
  int n_cycles = 0;
  logic [7:0] faults_seen = '0;

  int gap_pct = 0;
  int stall_pct = 0;
  int gap_left = 0;
  int burst_left = 0;
  int stall_left = 0;
  int run_left = 0;
  int run_lim = 0;
  read_kind_t run_kind = RD_GOOD;

  capture_health_reconnect_fsm u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // drop the session: index, counters, attempts, pending retry and fault
  function automatic void clear_session(inout health_state_t s);
    s.act_idx = '0;
    s.idx_valid = 1'b0;
    s.fails = '0;
    s.blacks = '0;
    s.attempts = '0;
    s.wait_left = '0;
    s.cause = C_NONE;
    s.fault = F_NONE;
  endfunction

  // error entry keeps the attempt count
  function automatic void enter_fault(inout health_state_t s, input logic [2:0] code);
    s.act_idx = '0;
    s.idx_valid = 1'b0;
    s.fails = '0;
    s.blacks = '0;
    s.wait_left = '0;
    s.cause = C_NONE;
    s.fault = code;
    s.mode = M_ERROR;
  endfunction

  // schedule a reconnect if attempts remain, delay grows with the attempt number
  function automatic logic try_retry(inout health_state_t s, input cfg_t c,
                                     input logic [1:0] why);
    if (s.attempts >= c.max_retry_attempts) return 1'b0;
    s.attempts = s.attempts + 4'd1;
    s.cause = why;
    s.wait_left = 20'(c.retry_base_delay) * 20'(s.attempts);
    s.fault = F_NONE;
    s.mode = M_RECONN;
    return 1'b1;
  endfunction

  // one request through the health monitor, returns the status it reports
  function automatic rsp_t advance_health(inout health_state_t s, input cfg_t c,
                                          input req_t r);
    rsp_t o;
    logic dark;
    o = '0;
    dark = r.mean_ch0 < c.black_level && r.mean_ch1 < c.black_level &&
           r.mean_ch2 < c.black_level;
    case (r.req_type)
      REQ_OPEN: begin
        o.release_device = 1'b1;
        clear_session(s);
        s.mode = M_OPENING;
        if (r.camera_index > MAX_INDEX) begin
          enter_fault(s, F_BAD_INDEX);
        end else if (!r.open_ok) begin
          enter_fault(s, F_OPEN_FAIL);
        end else begin
          s.act_idx = r.camera_index[3:0];
          s.idx_valid = 1'b1;
          s.mode = M_PLAYING;
        end
      end
      REQ_CLOSE: begin
        o.release_device = 1'b1;
        clear_session(s);
        if (s.mode != M_CLOSED && s.mode != M_STOPPED) s.mode = M_STOPPED;
      end
      REQ_TICK: begin
        if (s.wait_left != '0) s.wait_left = s.wait_left - 20'd1;
      end
      default: begin
        // read event: reopen when the retry is due, else count health
        if (s.mode == M_RECONN) begin
          if (s.wait_left == '0) begin
            o.release_device = 1'b1;
            if (r.open_ok) begin
              s.fails = '0;
              s.blacks = '0;
              s.cause = C_NONE;
              s.fault = F_NONE;
              s.mode = M_PLAYING;
            end else if (!try_retry(s, c, s.cause)) begin
              enter_fault(s, F_RETRIES);
            end
          end
        end else if (s.mode == M_PLAYING) begin
          if (r.frame_ok) begin
            s.fails = '0;
            if (dark) begin
              if (s.blacks != COUNT_MAX) s.blacks = s.blacks + 8'd1;
              if (s.blacks >= c.max_black_frames) begin
                o.release_device = 1'b1;
                if (!try_retry(s, c, C_BLACK)) enter_fault(s, F_BLACK);
              end
            end else begin
              s.blacks = '0;
              s.attempts = '0;
              o.frame_accepted = 1'b1;
            end
          end else begin
            if (s.fails != COUNT_MAX) s.fails = s.fails + 8'd1;
            if (s.fails >= c.max_read_failures) begin
              o.release_device = 1'b1;
              if (!try_retry(s, c, C_READS)) enter_fault(s, F_READS);
            end
          end
        end
      end
    endcase
    o.mode = s.mode;
    o.fault_code = s.fault;
    o.attempts_used = s.attempts;
    o.retry_cause = s.cause;
    return o;
  endfunction

  function automatic req_t mk_req(logic [1:0] kind, logic [7:0] idx, logic ok, logic fok,
                                  logic [15:0] m0, logic [15:0] m1, logic [15:0] m2);
    return '{kind, idx, ok, fok, m0, m1, m2};
  endfunction

  // read event with random content; black frames sit below the level, good ones not
  function automatic req_t make_read(read_kind_t k, logic [15:0] lvl);
    req_t r;
    int ch;
    logic [15:0] m [3];
    r = REQ_W'({$urandom(), $urandom()});
    r.req_type = REQ_READ;
    r.frame_ok = (k != RD_FAIL);
    m[0] = r.mean_ch0;
    m[1] = r.mean_ch1;
    m[2] = r.mean_ch2;
    if (k == RD_BLACK && lvl != 16'd0) begin
      foreach (m[i]) m[i] = ($urandom_range(4) == 0) ? lvl - 16'd1 :
                            16'($urandom_range(lvl - 16'd1, 0));
    end else if (k != RD_FAIL) begin
      ch = $urandom_range(2);
      m[ch] = ($urandom_range(4) == 0) ? lvl : 16'($urandom_range(16'hFFFF, lvl));
    end
    r.mean_ch0 = m[0];
    r.mean_ch1 = m[1];
    r.mean_ch2 = m[2];
    return r;
  endfunction

  task automatic push_request(req_t r);
    void'(advance_health(plan_state, model_cfg, r));
    request_q.push_back(r);
    n_pushed++;
  endtask

  // random requests shaped by the mode the block will be in
  task automatic gen_random(int n);
    req_t r;
    int pick;
    repeat (n) begin
      pick = $urandom_range(99);
      r = REQ_W'({$urandom(), $urandom()});
      case (plan_state.mode)
        M_PLAYING: begin
          if (pick < 3) begin
            r.req_type = REQ_CLOSE;
          end else if (pick < 5) begin
            r.req_type = REQ_OPEN;
          end else if (pick < 8) begin
            r.req_type = REQ_TICK;
          end else if (pick >= 10) begin
            // runs of failed, black or good reads, some long enough to hit the limits
            if (run_left == 0) begin
              case ($urandom_range(2))
                0: run_kind = RD_FAIL;
                1: run_kind = RD_BLACK;
                default: run_kind = RD_GOOD;
              endcase
              run_lim = (run_kind == RD_FAIL) ? int'(model_cfg.max_read_failures) :
                                                int'(model_cfg.max_black_frames);
              if (run_kind == RD_GOOD) run_left = $urandom_range(1, 4);
              else if ($urandom_range(1) == 0) run_left = run_lim + $urandom_range(2);
              else run_left = $urandom_range(1, run_lim + 1);
              if (run_left == 0) run_left = 1;
            end
            run_left--;
            if (run_lim <= 16 && $urandom_range(9) == 0) begin
              r = make_read(read_kind_t'($urandom_range(2)), model_cfg.black_level);
            end else begin
              r = make_read(run_kind, model_cfg.black_level);
            end
          end
        end
        M_RECONN: begin
          if (plan_state.wait_left == '0) begin
            r.req_type = (pick < 95) ? REQ_READ : REQ_CLOSE;
          end else if (plan_state.wait_left <= 20'd64) begin
            if (pick < 85) r.req_type = REQ_TICK;
            else if (pick < 95) r.req_type = REQ_READ;
            else if (pick < 98) r.req_type = REQ_CLOSE;
          end else begin
            // delay too long to tick out: tick, read, or leave the session
            if (pick < 40) r.req_type = REQ_TICK;
            else if (pick < 70) r.req_type = REQ_READ;
            else if (pick < 90) r.req_type = REQ_CLOSE;
            else r.req_type = REQ_OPEN;
          end
        end
        default: begin
          if (pick < 70) begin
            r.req_type = REQ_OPEN;
            r.camera_index = 8'($urandom_range(15));
            r.open_ok = 1'b1;
          end else if (pick < 78) begin
            r.req_type = REQ_OPEN;
            r.camera_index = 8'($urandom_range(255, 16));
          end else if (pick < 85) begin
            r.req_type = REQ_OPEN;
            r.camera_index = 8'($urandom_range(15));
            r.open_ok = 1'b0;
          end else if (pick < 90) begin
            r.req_type = REQ_CLOSE;
          end else if (pick < 95) begin
            r.req_type = REQ_TICK;
          end
        end
      endcase
      push_request(r);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (n_accepted != n_pushed || expected_status_q.size() != 0);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      R_MAX_READ_FAILURES:  model_cfg.max_read_failures = data[7:0];
      R_MAX_BLACK_FRAMES:   model_cfg.max_black_frames = data[7:0];
      R_MAX_RETRY_ATTEMPTS: model_cfg.max_retry_attempts = data[3:0];
      R_RETRY_BASE_DELAY:   model_cfg.retry_base_delay = data;
      R_BLACK_LEVEL:        model_cfg.black_level = data;
      default: ;
    endcase
    n_cfg_writes++;
    cfg_valid <= 1'b0;
  endtask

  // unused upper data bits carry junk on the narrow registers
  task automatic set_config(logic [7:0] f, logic [7:0] b, logic [3:0] a,
                            logic [15:0] d, logic [15:0] lvl);
    write_reg(R_MAX_READ_FAILURES, {8'($urandom), f});
    write_reg(R_MAX_BLACK_FRAMES, {8'($urandom), b});
    write_reg(R_MAX_RETRY_ATTEMPTS, {12'($urandom), a});
    write_reg(R_RETRY_BASE_DELAY, d);
    write_reg(R_BLACK_LEVEL, lvl);
  endtask

  // request driver: bursts with random gaps, payload held while stalled
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_status_q.push_back(advance_health(live_state, model_cfg, req_data));
        n_accepted++;
      end
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          req_data <= request_q.pop_front();
          req_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 20);
            if (gap_pct != 0 && $urandom_range(99) < gap_pct) gap_left = $urandom_range(1, 6);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare against the oldest expectation, stall in random runs
  always @(posedge clk) begin : result_monitor
    rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_status_q.size() == 0) begin
          $error("result with no request outstanding: %h", rsp_data);
          n_fail++;
        end else begin
          want = expected_status_q.pop_front();
          n_results++;
          if (rsp_data.frame_accepted !== want.frame_accepted) begin
            $error("frame_accepted: expected %0d, got %0d", want.frame_accepted,
                   rsp_data.frame_accepted);
            n_fail++;
          end
          if (rsp_data.mode !== want.mode) begin
            $error("mode: expected %0d, got %0d", want.mode, rsp_data.mode);
            n_fail++;
          end
          if (rsp_data.fault_code !== want.fault_code) begin
            $error("fault_code: expected %0d, got %0d", want.fault_code, rsp_data.fault_code);
            n_fail++;
          end
          if (rsp_data.attempts_used !== want.attempts_used) begin
            $error("attempts_used: expected %0d, got %0d", want.attempts_used,
                   rsp_data.attempts_used);
            n_fail++;
          end
          if (rsp_data.retry_cause !== want.retry_cause) begin
            $error("retry_cause: expected %0d, got %0d", want.retry_cause,
                   rsp_data.retry_cause);
            n_fail++;
          end
          if (rsp_data.release_device !== want.release_device) begin
            $error("release_device: expected %0d, got %0d", want.release_device,
                   rsp_data.release_device);
            n_fail++;
          end
          if (want.frame_accepted) n_frames++;
          if (want.release_device && want.mode == M_RECONN) n_retries++;
          faults_seen[want.fault_code] = 1'b1;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(6);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("capture_health_reconnect_fsm regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int n_items;
    clear_session(plan_state);
    plan_state.mode = M_CLOSED;
    live_state = plan_state;
    model_cfg = '{RST_MAX_READ_FAILURES, RST_MAX_BLACK_FRAMES, RST_MAX_RETRY_ATTEMPTS,
                  RST_RETRY_BASE_DELAY, RST_BLACK_LEVEL};
    gap_pct = 20;
    stall_pct = 20;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // closed-state requests, index checks, black threshold edges, close twice
    push_request(mk_req(REQ_READ, 8'h00, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push_request(mk_req(REQ_TICK, 8'hFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push_request(mk_req(REQ_CLOSE, 8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    push_request(mk_req(REQ_OPEN, 8'd16, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    push_request(mk_req(REQ_OPEN, 8'd255, 1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000));
    push_request(mk_req(REQ_OPEN, 8'd15, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000));
    push_request(mk_req(REQ_OPEN, 8'd0, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    push_request(mk_req(REQ_READ, 8'h00, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push_request(mk_req(REQ_READ, 8'h00, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000));
    push_request(mk_req(REQ_READ, 8'h00, 1'b0, 1'b1, 16'h0100, 16'h0000, 16'h0000));
    push_request(mk_req(REQ_READ, 8'h00, 1'b0, 1'b1, 16'h00FF, 16'h00FF, 16'h00FF));
    push_request(mk_req(REQ_READ, 8'h00, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push_request(mk_req(REQ_TICK, 8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    push_request(mk_req(REQ_CLOSE, 8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    push_request(mk_req(REQ_CLOSE, 8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    push_request(mk_req(REQ_OPEN, 8'd15, 1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000));
    wait_drained();

    // limits of one: retry waiting, failed reopen, reopen, black exhausted
    set_config(8'd1, 8'd1, 4'd1, 16'd1, RST_BLACK_LEVEL);
    push_request(mk_req(REQ_READ, 8'h00, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push_request(mk_req(REQ_READ, 8'h00, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push_request(mk_req(REQ_TICK, 8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    push_request(mk_req(REQ_READ, 8'h00, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    push_request(mk_req(REQ_OPEN, 8'd3, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    push_request(mk_req(REQ_READ, 8'h00, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000));
    push_request(mk_req(REQ_TICK, 8'h00, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000));
    push_request(mk_req(REQ_READ, 8'h00, 1'b1, 1'b1, 16'h0000, 16'h0000, 16'h0000));
    push_request(mk_req(REQ_READ, 8'h00, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000));
    wait_drained();

    // random phases: zero limits, maximum limits, defaults, then random settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_config(8'd0, 8'd0, 4'd0, 16'd0, 16'd0);
        1: set_config(8'd255, 8'd255, 4'd15, 16'hFFFF, 16'hFFFF);
        2: set_config(RST_MAX_READ_FAILURES, RST_MAX_BLACK_FRAMES, RST_MAX_RETRY_ATTEMPTS,
                      RST_RETRY_BASE_DELAY, RST_BLACK_LEVEL);
        default: set_config(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
                            4'($urandom_range(0, 6)), 16'($urandom_range(0, 12)),
                            16'($urandom));
      endcase
      if (p == 3) write_reg(R_UNUSED, 16'($urandom));
      if (p % 3 == 2) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = $urandom_range(5, 50);
        stall_pct = $urandom_range(5, 50);
      end
      run_left = 0;
      n_items = (p == 1) ? 400 : 140;
      gen_random(n_items / 2);
      // hold the sender until every outstanding result is back
      wait_drained();
      gen_random(n_items - n_items / 2);
      wait_drained();
    end

    repeat (6) @(negedge clk);
    $display("covered %0d requests over %0d random phases with %0d register writes",
             n_pushed, NUM_PHASES, n_cfg_writes);
    $display("%0d results checked, %0d frames accepted, %0d reconnects scheduled, faults seen %b",
             n_results, n_frames, n_retries, faults_seen[5:0]);
    if (n_fail == 0) begin
      $display("capture_health_reconnect_fsm regression: pass");
    end else begin
      $display("capture_health_reconnect_fsm regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/chr_pkg.sv
rtl/chr_cfg_regs.sv
rtl/chr_core.sv
rtl/capture_health_reconnect_fsm.sv
tb/sv/tb_capture_health_reconnect_fsm.sv
